// ===== hdl/hbmt_pkg.sv =====
// Package for the heartbeat membership table core.
// Types, codes and defaults shared by all modules; no dependencies.
package hbmt_pkg;

    localparam int MaxMembersDef = 16;

    typedef enum logic [1:0] {
        REQ_JOIN  = 2'd0,
        REQ_REPLY = 2'd1,
        REQ_GOSSIP = 2'd2,
        REQ_TICK  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        K_JOINREP = 2'd0,
        K_ROW     = 2'd1,
        K_STATUS  = 2'd2,
        K_TICK    = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IGNORED = 3'd0,
        ST_REFRESH = 3'd1,
        ST_ADDED   = 3'd2,
        ST_FAILED  = 3'd3,
        ST_DROPPED = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        CFG_ID     = 3'd0,
        CFG_PORT   = 3'd1,
        CFG_INTRO  = 3'd2,
        CFG_PERIOD = 3'd3,
        CFG_FAIL   = 3'd4,
        CFG_REMOVE = 3'd5
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_JOINREP,
        S_BCAST,
        S_AGE,
        S_TICKDONE
    } t_state;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [31:0]        member_id;
        logic [15:0]        member_port;
        logic signed [31:0] member_heartbeat;
    } t_in;

    typedef struct packed {
        logic [1:0]         kind;
        logic [31:0]        out_id;
        logic [15:0]        out_port;
        logic signed [31:0] out_heartbeat;
        logic [2:0]         merge_status;
        logic               last;
    } t_out;

    typedef struct packed {
        logic [31:0]        id;
        logic [15:0]        port;
        logic signed [31:0] hb;
        logic [31:0]        stamp;
    } t_entry;

endpackage

// ===== hdl/hbmt_table.sv =====
// Member table storage: one write port, one registered read port.
// Depends on hbmt_pkg.
module hbmt_table #(
    parameter int MAX_MEMBERS = hbmt_pkg::MaxMembersDef,
    localparam int AW = $clog2(MAX_MEMBERS)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  hbmt_pkg::t_entry  i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output hbmt_pkg::t_entry  o_rdata
);
    hbmt_pkg::t_entry r_mem [MAX_MEMBERS];
    hbmt_pkg::t_entry r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd <= r_mem[i_raddr];
    end

    assign o_rdata = r_rd;
endmodule

// ===== hdl/heartbeat_membership_table_core.sv =====
// Top level of the heartbeat membership table core.
// Depends on hbmt_pkg and hbmt_table.
//
// Usage: pulse i_start with an item on i_in while o_busy is low. Results come
// out on o_out marked by o_valid, one cycle each; the receiver cannot stall.
// A record (join request, join reply, gossip row) checks entry zero at accept,
// then searches the table one entry per cycle through the single read port;
// a join request then emits one more record, the reply. A tick with broadcast
// emits one row per entry, then ages every stored entry one per cycle through
// the same port. Other ticks after joining age only, then emit a tick done
// record; before joining, they emit only the tick done record. A new item is
// taken at the first edge with o_busy low.
// Entry zero (own id, port, heartbeat) lives in registers; the stored table
// holds entries 1 and up. Reset brings member_count to 1, countdown to
// ping_period, time to 0 and joined to 0; config to defaults.
// Configuration writes on i_cfg_we/i_cfg_idx/i_cfg_data take effect at once.
module heartbeat_membership_table_core #(
    parameter int MAX_MEMBERS = hbmt_pkg::MaxMembersDef,
    localparam int AW = $clog2(MAX_MEMBERS),
    localparam int CW = $clog2(MAX_MEMBERS + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output logic            o_busy,
    input  hbmt_pkg::t_in   i_in,
    output logic            o_valid,
    output hbmt_pkg::t_out  o_out,
    input  logic            i_cfg_we,
    input  logic [2:0]      i_cfg_idx,
    input  logic [31:0]     i_cfg_data
);
    hbmt_pkg::t_state r_state, n_state;
    logic [31:0] r_self_id;
    logic [15:0] r_self_port;
    logic [15:0] r_period, r_fail, r_remove, r_cd;
    logic signed [31:0] r_self_hb;
    logic [CW-1:0] r_count, r_rp, r_wp;
    logic [31:0] r_time;
    logic        r_joined;
    hbmt_pkg::t_in r_item;
    logic        r_pend;      // read issued last cycle
    logic [CW-1:0] r_pidx;
    logic        r_found;
    logic [CW-1:0] r_fidx;
    logic        r_bc;
    logic        r_ov;
    hbmt_pkg::t_out r_out;

    logic            we;
    logic [AW-1:0]   waddr, raddr;
    hbmt_pkg::t_entry wdata, rdata;

    hbmt_table #(.MAX_MEMBERS(MAX_MEMBERS)) u_tab (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    logic accept;
    assign accept = i_start && !o_busy;
    assign o_busy = (r_state != hbmt_pkg::S_IDLE);
    assign o_valid = r_ov;
    assign o_out = r_out;

    // combinational helpers
    logic [31:0] age;
    logic        match, scan_done;
    assign age = r_time - rdata.stamp;
    assign match = r_pend && rdata.id == r_item.member_id
                   && rdata.port == r_item.member_port;
    assign scan_done = (r_rp >= r_count);
    assign raddr = r_rp[AW-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            hbmt_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_in.req_type == hbmt_pkg::REQ_TICK) begin
                        n_state = hbmt_pkg::S_AGE;
                        if (r_joined && r_cd == 16'd0) begin
                            n_state = hbmt_pkg::S_BCAST;
                        end
                    end else begin
                        n_state = hbmt_pkg::S_SEARCH;
                    end
                end
            end
            hbmt_pkg::S_SEARCH: begin
                if ((r_found || (!r_pend && scan_done)) && !match) begin
                    n_state = (r_item.req_type == hbmt_pkg::REQ_JOIN)
                              ? hbmt_pkg::S_JOINREP : hbmt_pkg::S_IDLE;
                end
            end
            hbmt_pkg::S_JOINREP: n_state = hbmt_pkg::S_IDLE;
            hbmt_pkg::S_BCAST: begin
                if (!r_pend && scan_done) n_state = hbmt_pkg::S_AGE;
            end
            hbmt_pkg::S_AGE: begin
                if (!r_pend && (scan_done || !r_joined)) begin
                    n_state = r_bc ? hbmt_pkg::S_IDLE : hbmt_pkg::S_TICKDONE;
                end
            end
            hbmt_pkg::S_TICKDONE: n_state = hbmt_pkg::S_IDLE;
            default: n_state = hbmt_pkg::S_IDLE;
        endcase
    end

    // table write port
    always_comb begin
        we = 1'b0;
        waddr = r_wp[AW-1:0];
        wdata = rdata;
        case (r_state)
            hbmt_pkg::S_SEARCH: begin
                if (r_found) begin
                    // stored update already decided: r_fidx
                    waddr = r_fidx[AW-1:0];
                end else if (match && r_pidx != '0) begin
                    waddr = r_pidx[AW-1:0];
                    if (r_item.member_heartbeat == -32'sd1) begin
                        we = 1'b1;
                        wdata.hb = -32'sd1;
                    end else if (rdata.hb != -32'sd1
                                 && rdata.hb < r_item.member_heartbeat) begin
                        we = 1'b1;
                        wdata.hb = r_item.member_heartbeat;
                        wdata.stamp = r_time;
                    end
                end else if (!r_pend && scan_done && !r_found
                             && r_item.member_heartbeat != -32'sd1
                             && r_count < CW'(MAX_MEMBERS)) begin
                    we = 1'b1;
                    waddr = r_count[AW-1:0];
                    wdata.id = r_item.member_id;
                    wdata.port = r_item.member_port;
                    wdata.hb = r_item.member_heartbeat;
                    wdata.stamp = r_time;
                end
            end
            hbmt_pkg::S_AGE: begin
                if (r_pend && r_joined && age <= 32'(r_remove)) begin
                    we = 1'b1;
                    if (age > 32'(r_fail)) wdata.hb = -32'sd1;
                end
            end
            default: ;
        endcase
    end

    // self match on entry zero (checked at accept)
    logic self_match;
    assign self_match = i_in.member_id == r_self_id && i_in.member_port == r_self_port;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hbmt_pkg::S_IDLE;
            r_self_id <= '0;
            r_self_port <= '0;
            r_period <= 16'd2;
            r_fail <= 16'd5;
            r_remove <= 16'd20;
            r_cd <= 16'd2;
            r_self_hb <= '0;
            r_count <= CW'(1);
            r_time <= '0;
            r_joined <= 1'b0;
            r_ov <= 1'b0;
            r_pend <= 1'b0;
            r_found <= 1'b0;
            r_bc <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    hbmt_pkg::CFG_ID:     r_self_id <= i_cfg_data;
                    hbmt_pkg::CFG_PORT:   r_self_port <= i_cfg_data[15:0];
                    hbmt_pkg::CFG_INTRO: begin
                        if (i_cfg_data[0]) r_joined <= 1'b1;
                    end
                    hbmt_pkg::CFG_PERIOD: begin
                        r_period <= i_cfg_data[15:0];
                        r_cd <= i_cfg_data[15:0];
                    end
                    hbmt_pkg::CFG_FAIL:   r_fail <= i_cfg_data[15:0];
                    hbmt_pkg::CFG_REMOVE: r_remove <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            case (r_state)
                hbmt_pkg::S_IDLE: begin
                    r_rp <= CW'(1);
                    r_wp <= CW'(1);
                    r_pend <= 1'b0;
                    r_found <= 1'b0;
                    r_bc <= 1'b0;
                    if (accept) begin
                        r_item <= i_in;
                        if (i_in.req_type == hbmt_pkg::REQ_TICK) begin
                            if (r_joined) begin
                                if (r_cd == 16'd0) begin
                                    r_bc <= 1'b1;
                                    r_cd <= r_period;
                                    if (r_self_hb != 32'sh7fffffff)
                                        r_self_hb <= r_self_hb + 32'sd1;
                                    r_rp <= '0;
                                end else begin
                                    r_cd <= r_cd - 16'd1;
                                end
                            end
                        end else begin
                            if (i_in.req_type == hbmt_pkg::REQ_REPLY) r_joined <= 1'b1;
                            if (self_match) begin
                                r_found <= 1'b1;
                                r_fidx <= '0;
                                r_out.merge_status <= hbmt_pkg::ST_IGNORED;
                                if (i_in.member_heartbeat == -32'sd1) begin
                                    r_self_hb <= -32'sd1;
                                    r_out.merge_status <= hbmt_pkg::ST_FAILED;
                                end else if (r_self_hb != -32'sd1
                                             && r_self_hb < i_in.member_heartbeat) begin
                                    r_self_hb <= i_in.member_heartbeat;
                                    r_out.merge_status <= hbmt_pkg::ST_REFRESH;
                                end
                            end
                        end
                    end
                end
                hbmt_pkg::S_SEARCH: begin
                    if (!r_found) begin
                        r_pend <= !scan_done;
                        r_pidx <= r_rp;
                        if (!scan_done) r_rp <= r_rp + CW'(1);
                    end
                    if (match && !r_found) begin
                        r_found <= 1'b1;
                        r_fidx <= r_pidx;
                        r_pend <= 1'b0;
                        if (r_item.member_heartbeat == -32'sd1)
                            r_out.merge_status <= hbmt_pkg::ST_FAILED;
                        else if (rdata.hb != -32'sd1 && rdata.hb < r_item.member_heartbeat)
                            r_out.merge_status <= hbmt_pkg::ST_REFRESH;
                        else
                            r_out.merge_status <= hbmt_pkg::ST_IGNORED;
                    end else if (r_found || (!r_pend && scan_done)) begin
                        r_ov <= 1'b1;
                        r_out.kind <= hbmt_pkg::K_STATUS;
                        r_out.out_id <= r_item.member_id;
                        r_out.out_port <= r_item.member_port;
                        r_out.out_heartbeat <= r_item.member_heartbeat;
                        r_out.last <= (r_item.req_type != hbmt_pkg::REQ_JOIN);
                        if (!r_found) begin
                            if (r_item.member_heartbeat == -32'sd1) begin
                                r_out.merge_status <= hbmt_pkg::ST_IGNORED;
                            end else if (r_count >= CW'(MAX_MEMBERS)) begin
                                r_out.merge_status <= hbmt_pkg::ST_DROPPED;
                            end else begin
                                r_out.merge_status <= hbmt_pkg::ST_ADDED;
                                r_count <= r_count + CW'(1);
                            end
                        end
                    end
                end
                hbmt_pkg::S_JOINREP: begin
                    r_ov <= 1'b1;
                    r_out <= '{kind: hbmt_pkg::K_JOINREP, out_id: r_self_id,
                               out_port: r_self_port, out_heartbeat: r_self_hb,
                               merge_status: hbmt_pkg::ST_IGNORED, last: 1'b1};
                end
                hbmt_pkg::S_BCAST: begin
                    // index 0 from registers, others from table
                    if (r_rp == '0) begin
                        r_ov <= 1'b1;
                        r_out <= '{kind: hbmt_pkg::K_ROW, out_id: r_self_id,
                                   out_port: r_self_port, out_heartbeat: r_self_hb,
                                   merge_status: hbmt_pkg::ST_IGNORED,
                                   last: (r_count == CW'(1))};
                        r_rp <= CW'(1);
                        r_pend <= 1'b0;
                    end else begin
                        r_pend <= !scan_done;
                        r_pidx <= r_rp;
                        if (!scan_done) r_rp <= r_rp + CW'(1);
                        if (r_pend) begin
                            r_ov <= 1'b1;
                            r_out <= '{kind: hbmt_pkg::K_ROW, out_id: rdata.id,
                                       out_port: rdata.port, out_heartbeat: rdata.hb,
                                       merge_status: hbmt_pkg::ST_IGNORED,
                                       last: (r_pidx + CW'(1) == r_count)};
                        end
                        if (!r_pend && scan_done) r_rp <= CW'(1);
                    end
                end
                hbmt_pkg::S_AGE: begin
                    r_pend <= r_joined && !scan_done;
                    if (!scan_done) r_rp <= r_rp + CW'(1);
                    if (we) r_wp <= r_wp + CW'(1);
                    if (!r_pend && (scan_done || !r_joined)) begin
                        r_time <= r_time + 32'd1;
                        if (r_joined) r_count <= r_wp;
                    end
                end
                hbmt_pkg::S_TICKDONE: begin
                    r_ov <= 1'b1;
                    r_out <= '{kind: hbmt_pkg::K_TICK, out_id: '0, out_port: '0,
                               out_heartbeat: '0, merge_status: hbmt_pkg::ST_IGNORED,
                               last: 1'b1};
                end
                default: ;
            endcase
        end
    end
endmodule
